### src/mer_pkg.sv
// ----------------------------------------------------------------------------
// mer_pkg
// Shared constants and types for the midpoint ellipse rasterizer.
// ----------------------------------------------------------------------------
package mer_pkg;

  // Default geometry
  localparam int CoordBitsDef = 12;
  localparam int AxisBitsDef  = 10;

  // Decision variable width
  localparam int DecBits = 48;

  // Result slots per step (four mirrored points at most)
  localparam int ResSlots = 4;

  // Configuration port
  localparam int CfgAddrBits = 5;
  localparam int CfgDataBits = 32;
  localparam int ColourBits  = 8;

  typedef enum logic [2:0] {
    CFG_CENTER_X = 3'd0,
    CFG_CENTER_Y = 3'd1,
    CFG_AXIS_A   = 3'd2,
    CFG_AXIS_B   = 3'd3,
    CFG_FILL     = 3'd4,
    CFG_COLOUR   = 3'd5
  } cfg_reg_e;

  // Walk region of the first quadrant
  typedef enum logic [1:0] {
    REG_ONE  = 2'd0,
    REG_TWO  = 2'd1,
    REG_DONE = 2'd2
  } region_e;

endpackage

### src/midpoint_ellipse_rasterizer.sv
// Flow: an input transaction is registered, then processed once the result buffer is free,
//   and processing registers its results in that buffer; a restart gives no result.
// Throughput: one result per cycle through the single result port unless it is stalled,
//   four per advance tick in outline, two in filled mode; restarts every cycle when idle.
// Reset: walk region to done, config, square and walk registers zero, buffer empty.
// ----------------------------------------------------------------------------
// midpoint_ellipse_rasterizer
// Midpoint ellipse walker with an APB-style register port; each advance tick
// emits four mirrored points or two horizontal spans.
// ----------------------------------------------------------------------------
module midpoint_ellipse_rasterizer #(
  parameter int COORD_BITS = mer_pkg::CoordBitsDef,
  parameter int AXIS_BITS  = mer_pkg::AxisBitsDef
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // configuration port
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [mer_pkg::CfgAddrBits-1:0]        paddr,
  input  logic [mer_pkg::CfgDataBits-1:0]        pwdata,
  output logic [mer_pkg::CfgDataBits-1:0]        prdata,
  output logic                                   pready,
  // input channel
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic                                   restart_i,
  // result channel
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic signed [COORD_BITS-1:0]           x_left_o,
  output logic signed [COORD_BITS-1:0]           x_right_o,
  output logic signed [COORD_BITS-1:0]           y_coord_o,
  output logic [mer_pkg::ColourBits-1:0]         colour_out_o,
  output logic                                   last_of_step_o,
  output logic                                   ellipse_done_o
);

  localparam int SqBits  = 2 * AXIS_BITS;
  localparam int DecBits = mer_pkg::DecBits;
  localparam int Slots   = mer_pkg::ResSlots;
  localparam int CntBits = $clog2(Slots + 1);
  localparam int KBits   = AXIS_BITS + 3;               // 4*axis-1
  localparam int PwC     = SqBits + COORD_BITS + 1;     // square * coord
  localparam int PwO     = SqBits + COORD_BITS + 2;     // square * (2*coord+1)
  localparam int PwK     = SqBits + KBits + 1;          // square * (4*axis-1)
  localparam int DW      = mer_pkg::CfgDataBits;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic signed [COORD_BITS-1:0] cx_q, cy_q;
  logic [AXIS_BITS-1:0]         ax_q, bx_q;
  logic [SqBits-1:0]            sqa_q, sqb_q;
  logic                         fill_q;
  logic [mer_pkg::ColourBits-1:0] colour_q;
  logic                         cfg_wr;
  logic [AXIS_BITS-1:0]         wr_axis;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign wr_axis = pwdata[AXIS_BITS-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q     <= '0;
      cy_q     <= '0;
      ax_q     <= '0;
      bx_q     <= '0;
      sqa_q    <= '0;
      sqb_q    <= '0;
      fill_q   <= 1'b0;
      colour_q <= '0;
    end else if (cfg_wr) begin
      case (mer_pkg::cfg_reg_e'(paddr[4:2]))
        mer_pkg::CFG_CENTER_X: cx_q <= pwdata[COORD_BITS-1:0];
        mer_pkg::CFG_CENTER_Y: cy_q <= pwdata[COORD_BITS-1:0];
        mer_pkg::CFG_AXIS_A: begin
          ax_q  <= wr_axis;
          // keep the square ready for the next restart
          sqa_q <= SqBits'(wr_axis) * SqBits'(wr_axis);
        end
        mer_pkg::CFG_AXIS_B: begin
          bx_q  <= wr_axis;
          sqb_q <= SqBits'(wr_axis) * SqBits'(wr_axis);
        end
        mer_pkg::CFG_FILL:   fill_q   <= pwdata[0];
        mer_pkg::CFG_COLOUR: colour_q <= pwdata[mer_pkg::ColourBits-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (mer_pkg::cfg_reg_e'(paddr[4:2]))
      mer_pkg::CFG_CENTER_X: prdata = DW'({{DW{1'b0}}, cx_q});
      mer_pkg::CFG_CENTER_Y: prdata = DW'({{DW{1'b0}}, cy_q});
      mer_pkg::CFG_AXIS_A:   prdata = DW'({{DW{1'b0}}, ax_q});
      mer_pkg::CFG_AXIS_B:   prdata = DW'({{DW{1'b0}}, bx_q});
      mer_pkg::CFG_FILL:     prdata = DW'({{DW{1'b0}}, fill_q});
      mer_pkg::CFG_COLOUR:   prdata = DW'({{DW{1'b0}}, colour_q});
      default:               prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Input register and buffer handshake
  // --------------------------------------------------------------------------
  logic               in_vld_q, restart_q;
  logic [CntBits-1:0] cnt_q;
  logic               out_take, buf_free, proc, load;

  assign out_valid_o = (cnt_q != '0);
  assign out_take    = out_valid_o & ~out_stall_i;
  assign buf_free    = (cnt_q == '0) || ((cnt_q == CntBits'(1)) && out_take);
  assign proc        = in_vld_q & buf_free;
  assign in_stall_o  = in_vld_q & ~buf_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      restart_q <= restart_i;
    end
  end

  // --------------------------------------------------------------------------
  // Walk state
  // --------------------------------------------------------------------------
  logic signed [COORD_BITS-1:0] sx_q, sy_q, sx_d, sy_d;
  logic signed [DecBits-1:0]    dec_q, dec_d;
  logic [SqBits-1:0]            a2_q, b2_q, a2_d, b2_d;
  mer_pkg::region_e             region_q, region_d;

  logic                         dec_neg, in_one, active, stay;
  logic signed [COORD_BITS-1:0] nx, ny, ax_c, bx_c;
  logic signed [PwC-1:0]        m_ay, m_bx;
  logic signed [PwO-1:0]        m_ayo, m_bxo;
  logic signed [PwK-1:0]        m_k;
  logic signed [KBits-1:0]      k_op;
  logic [SqBits-1:0]            sq_op, sq_sub;
  logic signed [DecBits-1:0]    e_ay, e_bx, e_ayo, e_bxo, e_k, d_one, d_two, d_init;

  assign dec_neg = dec_q[DecBits-1];
  assign in_one  = (region_q == mer_pkg::REG_ONE);
  assign active  = (region_q == mer_pkg::REG_ONE) || (region_q == mer_pkg::REG_TWO);
  assign ax_c    = COORD_BITS'({{COORD_BITS{1'b0}}, ax_q});
  assign bx_c    = COORD_BITS'({{COORD_BITS{1'b0}}, bx_q});

  // Region one always steps x, region two always steps y
  assign nx = in_one ? sx_q + 1'b1 : (dec_neg ? sx_q - 1'b1 : sx_q);
  assign ny = in_one ? (dec_neg ? sy_q - 1'b1 : sy_q) : sy_q + 1'b1;

  assign m_ay  = $signed({1'b0, a2_q}) * ny;
  assign m_bx  = $signed({1'b0, b2_q}) * nx;
  assign m_ayo = $signed({1'b0, a2_q}) * $signed({ny, 1'b1});
  assign m_bxo = $signed({1'b0, b2_q}) * $signed({nx, 1'b1});

  // Shared start-of-region multiplier: restart or switch into region two
  assign sq_op  = restart_q ? sqa_q : b2_q;
  assign sq_sub = restart_q ? sqb_q : a2_q;
  assign k_op   = restart_q ? $signed({1'b0, bx_q, 2'b00}) - KBits'(1)
                            : $signed({1'b0, ax_q, 2'b00}) - KBits'(1);
  assign m_k    = $signed({1'b0, sq_op}) * k_op;

  assign e_ay  = $signed({{(DecBits-PwC){m_ay[PwC-1]}}, m_ay});
  assign e_bx  = $signed({{(DecBits-PwC){m_bx[PwC-1]}}, m_bx});
  assign e_ayo = $signed({{(DecBits-PwO){m_ayo[PwO-1]}}, m_ayo});
  assign e_bxo = $signed({{(DecBits-PwO){m_bxo[PwO-1]}}, m_bxo});
  assign e_k   = $signed({{(DecBits-PwK){m_k[PwK-1]}}, m_k});

  assign d_one  = dec_q - (e_bxo <<< 2) + (dec_neg ? (e_ay <<< 3) : '0);
  assign d_two  = dec_q - (e_ayo <<< 2) + (dec_neg ? (e_bx <<< 3) : '0);
  assign d_init = e_k - $signed({{(DecBits-SqBits-2){1'b0}}, sq_sub, 2'b00});

  assign stay = in_one ? (m_ay >= m_bx) : (m_ay <= m_bx);

  always_comb begin
    sx_d     = sx_q;
    sy_d     = sy_q;
    dec_d    = dec_q;
    a2_d     = a2_q;
    b2_d     = b2_q;
    region_d = region_q;
    if (proc) begin
      if (restart_q) begin
        a2_d     = sqa_q;
        b2_d     = sqb_q;
        sx_d     = '0;
        sy_d     = bx_c;
        dec_d    = d_init;
        region_d = mer_pkg::REG_ONE;
      end else begin
        case (region_q)
          mer_pkg::REG_ONE: begin
            if (stay) begin
              sx_d  = nx;
              sy_d  = ny;
              dec_d = d_one;
            end else begin
              // switch to region two from (a, 0)
              sx_d     = ax_c;
              sy_d     = '0;
              dec_d    = d_init;
              region_d = mer_pkg::REG_TWO;
            end
          end
          mer_pkg::REG_TWO: begin
            sx_d  = nx;
            sy_d  = ny;
            dec_d = d_two;
            if (!stay) begin
              region_d = mer_pkg::REG_DONE;
            end
          end
          default: region_d = mer_pkg::REG_DONE;
        endcase
        if (a2_q == '0 && b2_q == '0) begin
          region_d = mer_pkg::REG_DONE;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sx_q     <= '0;
      sy_q     <= '0;
      dec_q    <= '0;
      a2_q     <= '0;
      b2_q     <= '0;
      region_q <= mer_pkg::REG_DONE;
    end else begin
      sx_q     <= sx_d;
      sy_q     <= sy_d;
      dec_q    <= dec_d;
      a2_q     <= a2_d;
      b2_q     <= b2_d;
      region_q <= region_d;
    end
  end

  // --------------------------------------------------------------------------
  // Result buffer: entry 0 drives the port, shift down on each take
  // --------------------------------------------------------------------------
  logic signed [COORD_BITS-1:0]   xp, xm, yp, ym;
  logic                           step_done;
  logic signed [COORD_BITS-1:0]   xl_n [Slots];
  logic signed [COORD_BITS-1:0]   xr_n [Slots];
  logic signed [COORD_BITS-1:0]   yc_n [Slots];
  logic [Slots-1:0]               last_n;
  logic [CntBits-1:0]             n_res;
  logic signed [COORD_BITS-1:0]   xl_q [Slots];
  logic signed [COORD_BITS-1:0]   xr_q [Slots];
  logic signed [COORD_BITS-1:0]   yc_q [Slots];
  logic [mer_pkg::ColourBits-1:0] col_q [Slots];
  logic [Slots-1:0]               last_q, done_q;

  assign xp        = cx_q + sx_q;
  assign xm        = cx_q - sx_q;
  assign yp        = cy_q + sy_q;
  assign ym        = cy_q - sy_q;
  assign step_done = (region_d == mer_pkg::REG_DONE);
  assign load      = proc & ~restart_q & active;

  always_comb begin
    if (fill_q) begin
      xl_n   = '{xm, xm, xm, xm};
      xr_n   = '{xp, xp, xp, xp};
      yc_n   = '{yp, ym, yp, ym};
      last_n = Slots'(2);
      n_res  = CntBits'(2);
    end else begin
      xl_n   = '{xp, xp, xm, xm};
      xr_n   = '{xp, xp, xm, xm};
      yc_n   = '{yp, ym, yp, ym};
      last_n = Slots'(8);
      n_res  = CntBits'(Slots);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      for (int i = 0; i < Slots; i++) begin
        xl_q[i]   <= xl_n[i];
        xr_q[i]   <= xr_n[i];
        yc_q[i]   <= yc_n[i];
        col_q[i]  <= colour_q;
        last_q[i] <= last_n[i];
        done_q[i] <= step_done;
      end
    end else if (out_take) begin
      for (int i = 0; i < Slots - 1; i++) begin
        xl_q[i]   <= xl_q[i+1];
        xr_q[i]   <= xr_q[i+1];
        yc_q[i]   <= yc_q[i+1];
        col_q[i]  <= col_q[i+1];
        last_q[i] <= last_q[i+1];
        done_q[i] <= done_q[i+1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (load) begin
      cnt_q <= n_res;
    end else if (out_take) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  assign x_left_o       = xl_q[0];
  assign x_right_o      = xr_q[0];
  assign y_coord_o      = yc_q[0];
  assign colour_out_o   = col_q[0];
  assign last_of_step_o = last_q[0];
  assign ellipse_done_o = done_q[0];

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntBits'(Slots))
    else $error("result count out of range");

  a_load_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> (cnt_q == '0) || ((cnt_q == CntBits'(1)) && out_take))
    else $error("buffer reloaded while results pending");

  a_last_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_of_step_o) |-> (cnt_q == CntBits'(1)))
    else $error("last flag not on final buffered result");

  a_restart_region: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && restart_q) |=> (region_q == mer_pkg::REG_ONE))
    else $error("restart did not enter region one");

  a_done_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((region_q == mer_pkg::REG_DONE) && !(proc && restart_q)) |=>
      (region_q == mer_pkg::REG_DONE))
    else $error("finished walk resumed without restart");

endmodule
